/* hw/rtl/swmmm_pkg.sv */
package swmmm_pkg;

	localparam int WINDOW    = 60;
	localparam int SAMPLE_W  = 24;
	localparam int SUM_W     = 32;
	localparam int IDX_W     = $clog2(WINDOW);
	// magnitude of the window sum, reciprocal of WINDOW scaled by 2**DIV_SHIFT
	localparam int MAG_W     = SAMPLE_W + IDX_W;
	localparam int DIV_SHIFT = MAG_W + IDX_W;
	localparam int RECIP_W   = MAG_W + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;

endpackage

/* hw/rtl/swmmm_div.sv */
// Divide a signed sum by WINDOW, truncated toward zero: multiply the magnitude
// by a scaled reciprocal, shift, then restore the sign. The quotient registers while busy is high.
module swmmm_div import swmmm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  sum_t    dividend,
	output logic    busy,
	output sample_t quotient
);

	localparam int PROD_W = MAG_W + RECIP_W;

	logic                busy_q;
	logic                neg_q;
	logic [MAG_W-1:0]    mag_q;
	logic [SAMPLE_W-1:0] quo_q;
	logic [SUM_W-1:0]    mag;
	logic [PROD_W-1:0]   prod;

	assign mag  = dividend[SUM_W-1] ? -dividend : dividend;
	assign prod = PROD_W'(mag_q) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else
			busy_q <= start;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			mag_q <= mag[MAG_W-1:0];
		end
		if (busy_q)
			quo_q <= prod[DIV_SHIFT +: SAMPLE_W];
	end

	assign quotient = neg_q ? sample_t'(-quo_q) : sample_t'(quo_q);
	assign busy     = busy_q;

endmodule

/* hw/rtl/sliding_window_min_max_mean_unit.sv */
// Sliding-window minimum, maximum and mean over the last WINDOW samples.
//
// Input channel: in_valid / in_ready with a signed Q16.8 sample word.
// Output channel: out_valid / out_ready with window_min, window_max and
// window_mean (sum over the window divided by WINDOW, truncated toward zero).
// Each input word yields exactly one output word; one word is in flight at a time.
//
// Sequence for a word that finds the window primed: after acceptance, read
// the oldest entry, update the running sum and overwrite it; walk the window
// memory for min/max; fold the last read; load the output register. The
// divider runs during that walk. in_ready is high only while idle, so a new
// word is taken only once the block is through with the last one. The first
// word after reset first fills all WINDOW entries, one per cycle, before that
// update.
//
// Reset clears the sequencer, the primed flag, the running sum and the
// oldest-entry pointer; window memory contents are left as they are and are
// never read before the fill. A result held on a stalled output register
// keeps the block from finishing the next word but does not block accepting it.
module sliding_window_min_max_mean_unit import swmmm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  sample_t sample,
	output logic    out_valid,
	input  logic    out_ready,
	output sample_t window_min,
	output sample_t window_max,
	output sample_t window_mean
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FILL  = 3'd1;
	localparam logic [2:0] ST_RDOLD = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]     state_q;
	logic           primed_q;
	sum_t           sum_q;
	logic [IDX_W-1:0] oldest_q;
	logic [IDX_W-1:0] idx_q;
	sample_t        s_q;

	// window memory
	sample_t        mem [WINDOW];
	logic           wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	sample_t        rd_data_q;

	// scan fold
	logic           rv_s1;
	logic           first_s1;
	sample_t        min_q;
	sample_t        max_q;

	// divider
	logic           div_start;
	logic           div_busy;
	sample_t        div_quo;

	// output register
	logic           out_valid_q;
	sample_t        min_out_q;
	sample_t        max_out_q;
	sample_t        mean_out_q;

	logic           accept;
	logic           last_idx;
	logic           finish;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign last_idx  = idx_q == IDX_W'(WINDOW-1);
	assign div_start = (state_q == ST_SCAN) && (idx_q == '0);
	assign finish    = (state_q == ST_FIN) && !rv_s1 && !div_busy
	                   && (!out_valid_q || out_ready);

	// write the sample while filling, and over the oldest entry on update
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = oldest_q;
		rd_addr = oldest_q;
		if (state_q == ST_FILL) begin
			wr_en   = 1'b1;
			wr_addr = idx_q;
		end else if (state_q == ST_RDOLD) begin
			wr_en   = 1'b1;
		end else if (state_q == ST_SCAN) begin
			rd_addr = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= s_q;
		rd_data_q <= mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			primed_q <= 1'b0;
			sum_q    <= '0;
			oldest_q <= '0;
			idx_q    <= '0;
			rv_s1    <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			rv_s1    <= state_q == ST_SCAN;
			first_s1 <= div_start;
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept)
						state_q <= primed_q ? ST_RDOLD : ST_FILL;
				end
				ST_FILL: begin
					// build the running sum by adding the sample once per entry
					sum_q <= (idx_q == '0) ? SUM_W'(s_q) : sum_q + SUM_W'(s_q);
					if (last_idx) begin
						idx_q    <= '0;
						primed_q <= 1'b1;
						state_q  <= ST_RDOLD;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_RDOLD: begin
					// drop the oldest entry from the sum, add the new one
					sum_q    <= sum_q - SUM_W'(rd_data_q) + SUM_W'(s_q);
					oldest_q <= (oldest_q == IDX_W'(WINDOW-1)) ? '0 : oldest_q + IDX_W'(1);
					idx_q    <= '0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (last_idx) begin
						idx_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_FIN: begin
					if (finish)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			s_q <= sample;
		if (rv_s1) begin
			if (first_s1 || rd_data_q < min_q)
				min_q <= rd_data_q;
			if (first_s1 || rd_data_q > max_q)
				max_q <= rd_data_q;
		end
	end

	swmmm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// output register: hold the word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (finish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			min_out_q  <= min_q;
			max_out_q  <= max_q;
			mean_out_q <= div_quo;
		end
	end

	assign in_ready    = state_q == ST_IDLE;
	assign out_valid   = out_valid_q;
	assign window_min  = min_out_q;
	assign window_max  = max_out_q;
	assign window_mean = mean_out_q;

endmodule

/* verif/swmmm_window_checker.sv */
`timescale 1ns / 1ps

module swmmm_window_checker import swmmm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_ready,
	input  sample_t sample,
	input  logic    out_valid,
	input  logic    out_ready,
	input  sample_t window_min,
	input  sample_t window_max,
	input  sample_t window_mean,
	output int      fail_count,
	output int      stats_pending
);

	typedef struct packed {
		sample_t lo;
		sample_t hi;
		sample_t mean;
	} window_stats_t;

	sample_t          window_copy [WINDOW];
	logic             primed;
	sum_t             running_sum;
	logic [IDX_W-1:0] oldest;
	window_stats_t    expected_stats [$];

	// Shift one sample into the window copy; fill the whole window on the first one.
	function automatic window_stats_t fold_sample(input sample_t s);
		window_stats_t st;
		if (!primed) begin
			foreach (window_copy[i])
				window_copy[i] = s;
			running_sum = sum_t'(s) * sum_t'(WINDOW);
			oldest      = '0;
			primed      = 1'b1;
		end
		running_sum = running_sum - sum_t'(window_copy[oldest]) + sum_t'(s);
		window_copy[oldest] = s;
		oldest = (oldest == IDX_W'(WINDOW - 1)) ? '0 : oldest + IDX_W'(1);
		st.lo = window_copy[0];
		st.hi = window_copy[0];
		for (int i = 1; i < WINDOW; i++) begin
			if (window_copy[i] < st.lo)
				st.lo = window_copy[i];
			if (window_copy[i] > st.hi)
				st.hi = window_copy[i];
		end
		// signed division truncates toward zero
		st.mean = sample_t'(running_sum / sum_t'(WINDOW));
		return st;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		window_stats_t want;
		int            errs;
		errs = 0;
		if (!arst_n) begin
			primed      = 1'b0;
			running_sum = '0;
			oldest      = '0;
			expected_stats.delete();
			stats_pending <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_stats.push_back(fold_sample(sample));
			if (out_valid && out_ready) begin
				if (expected_stats.size() == 0) begin
					$error("result word with nothing expected: min %0d max %0d mean %0d",
						window_min, window_max, window_mean);
					errs++;
				end else begin
					want = expected_stats.pop_front();
					if (window_min !== want.lo) begin
						$error("window_min: expected %0d, got %0d", want.lo, window_min);
						errs++;
					end
					if (window_max !== want.hi) begin
						$error("window_max: expected %0d, got %0d", want.hi, window_max);
						errs++;
					end
					if (window_mean !== want.mean) begin
						$error("window_mean: expected %0d, got %0d", want.mean, window_mean);
						errs++;
					end
				end
			end
			fail_count    <= fail_count + errs;
			stats_pending <= expected_stats.size();
		end
	end

endmodule

/* verif/sliding_window_min_max_mean_unit_tb.sv */
`timescale 1ns / 1ps

module sliding_window_min_max_mean_unit_tb;
	import swmmm_pkg::*;

	// Random words per idling phase; four phases give about 800 words.
	localparam int PHASE_WORDS = 200;
	localparam int PHASES      = 4;
	// Phases: no idling, sender idle, receiver stalling, both.
	localparam int SEND_IDLE_PCT [PHASES] = '{0, 74, 0, 25};
	localparam int STALL_PCT     [PHASES] = '{0, 0, 74, 25};
	// Cycles without any handshake before declaring the block hung. The slowest
	// legal gap is the first word (fill plus walk) plus a long receiver stall,
	// so this leaves a wide margin.
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE      = WINDOW + 16;

	localparam sample_t MOST_POS = sample_t'(24'h7FFFFF);
	localparam sample_t MOST_NEG = sample_t'(24'h800000);

	// Directed words: the first one primes the window, then extremes of the
	// range, sign boundaries, alternating bit patterns and Q16.8 unit steps.
	localparam int N_DIRECTED = 18;
	localparam sample_t DIRECTED_WORDS [N_DIRECTED] = '{
		sample_t'(-300), MOST_POS, MOST_NEG, sample_t'(0), sample_t'(-1), sample_t'(1),
		MOST_POS, MOST_POS, MOST_NEG,
		sample_t'(24'h555555), sample_t'(24'hAAAAAA), sample_t'(256), sample_t'(-256),
		sample_t'(128), sample_t'(-129),
		sample_t'(24'h7FFF00), sample_t'(24'h800100), sample_t'(-59)
	};

	logic    clk = 1'b0;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	sample_t sample;
	logic    out_valid;
	logic    out_ready = 1'b0;
	sample_t window_min;
	sample_t window_max;
	sample_t window_mean;

	int      fail_count;
	int      stats_pending;
	int      send_idle_pct;
	int      stall_pct;
	int      quiet_cycles = 0;
	// State of the random word source: constant runs and the last word sent.
	int      run_left;
	sample_t run_word;
	sample_t last_word;

	sliding_window_min_max_mean_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.window_min (window_min),
		.window_max (window_max),
		.window_mean(window_mean)
	);

	swmmm_window_checker u_window_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.window_min   (window_min),
		.window_max   (window_max),
		.window_mean  (window_mean),
		.fail_count   (fail_count),
		.stats_pending(stats_pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: drop ready at random in the stalling phases, hold it high otherwise.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog: end the run if no word moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Pick the next random word. Mostly full-range noise, extremes and small
	// values; now and then a constant run at least as long as the window, so that the
	// whole window holds one value and the mean reaches the range limits.
	function automatic sample_t pick_word();
		int roll;
		roll = $urandom_range(0, 99);
		if (run_left > 0) begin
			run_left--;
			return run_word;
		end
		if (roll < 3) begin
			case ($urandom_range(0, 3))
				0: run_word = MOST_POS;
				1: run_word = MOST_NEG;
				default: run_word = sample_t'($urandom);
			endcase
			run_left = $urandom_range(WINDOW - 1, WINDOW + 10);
			return run_word;
		end
		if (roll < 45)
			return sample_t'($urandom);
		if (roll < 65) begin
			case ($urandom_range(0, 4))
				0: return MOST_POS;
				1: return MOST_NEG;
				2: return sample_t'(0);
				3: return sample_t'(-1);
				default: return sample_t'(1);
			endcase
		end
		if (roll < 85)
			return sample_t'(int'($urandom_range(0, 2000)) - 1000);
		// nudge the last word to get long stretches of near-equal entries
		return last_word + sample_t'(int'($urandom_range(0, 8)) - 4);
	endfunction

	// Offer one word and hold it until accepted. Idle the sender first at
	// random; keep valid high straight into the next word when not idling.
	task automatic push_word(input sample_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample    <= w;
		last_word = w;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Hold the sender off until every expected result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (stats_pending != 0);
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		sample        = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		run_left      = 0;
		run_word      = '0;
		last_word     = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words run with the receiver always ready.
		foreach (DIRECTED_WORDS[i])
			push_word(DIRECTED_WORDS[i]);
		drain_results();

		// Random words, one idling phase after another; drain between phases.
		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct = SEND_IDLE_PCT[p];
			stall_pct     = STALL_PCT[p];
			repeat (PHASE_WORDS)
				push_word(pick_word());
			drain_results();
		end

		// Let any stray result word show up before the verdict.
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && stats_pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
